### sv/prqs_pkg.sv
// Shared types and constants for the priority ready queue scheduler.
// No dependencies; imported by every module of the block.
package prqs_pkg;

	localparam int unsigned NUM_THREADS = 16;
	localparam int unsigned ID_W        = 4;
	localparam int unsigned LEN_W       = 5;
	localparam int unsigned TL_W        = 34;

	localparam logic [30:0]     QUANTUM_RESET = 31'd10000000;
	localparam logic [8:0]      EMPTY_PRIO    = 9'd256;
	localparam logic [TL_W-1:0] TL_RESET      = 34'd10000000;

	// Operation codes
	localparam logic [3:0] OP_ENQ    = 4'd0;
	localparam logic [3:0] OP_REM    = 4'd1;
	localparam logic [3:0] OP_SWITCH = 4'd2;
	localparam logic [3:0] OP_TICK   = 4'd3;
	localparam logic [3:0] OP_YIELD  = 4'd4;
	localparam logic [3:0] OP_SETP   = 4'd5;
	localparam logic [3:0] OP_SETPOL = 4'd6;
	localparam logic [3:0] OP_LOCK   = 4'd7;
	localparam logic [3:0] OP_UNLOCK = 4'd8;

	// Reschedule reasons
	localparam logic [1:0] RS_NONE    = 2'd0;
	localparam logic [1:0] RS_SWITCH  = 2'd1;
	localparam logic [1:0] RS_PREEMPT = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_FIND, S_FDONE, S_REMOVE, S_PSTART, S_PSCAN,
		S_PSHIFT, S_MARK, S_SWPOP, S_TICK1, S_TICK2, S_TOP, S_OUT
	} state_t;

endpackage

### sv/priority_ready_queue_scheduler.sv
// Priority ready queue scheduler: sequencer, queue slots and thread tables.
// Depends on prqs_pkg and prqs_tick.
//
// Usage: one request enters on in_valid/in_ready with op, thread_id, prio,
// runnable, policy_rr and elapsed_ns. Exactly one result leaves on
// out_valid/out_ready: active thread, changed flag, pending reason,
// switch request, head priority (256 when empty), queue length, status.
// The quantum register is written through cfg_valid/cfg_data; cfg_ready
// is always high and writes are meant for idle periods.
// The sequencer walks the ready queue one slot per cycle with a single
// compare path. Find and place each scan the queue and remove shifts the
// later entries down, so enqueue or set_prio of a queued thread runs find,
// remove and place in turn.
// One request at a time: in_ready is low from acceptance until the result
// is taken. A stalled receiver holds the result and the block.
// Reset clears the queue, sets all priorities to 255, all policies to
// round robin, time left to 10 ms, active thread 0, no lock.
module priority_ready_queue_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [30:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  op,
	input  logic [3:0]  thread_id,
	input  logic [7:0]  prio,
	input  logic        runnable,
	input  logic        policy_rr,
	input  logic [31:0] elapsed_ns,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  active_id,
	output logic        changed,
	output logic [1:0]  resched_reason,
	output logic        switch_request,
	output logic [8:0]  top_prio,
	output logic [4:0]  queue_count,
	output logic [1:0]  status
);
	import prqs_pkg::*;

	state_t state_q, state_d;
	state_t ret_q;

	// latched request
	logic [3:0]  op_q;
	logic [ID_W-1:0] tid_q;
	logic [7:0]  pin_q;
	logic        run_q;
	logic        pol_q;
	logic [31:0] elap_q;

	logic [30:0] quantum_q;
	logic [ID_W-1:0] queue_q [NUM_THREADS];
	logic [7:0]  prio_q [NUM_THREADS];
	logic        rr_q [NUM_THREADS];
	logic signed [TL_W-1:0] tl_q [NUM_THREADS];
	logic [LEN_W-1:0] len_q, idx_q, pos_q, slot_q;
	logic [ID_W-1:0]  cur_q, place_id_q;
	logic [7:0]  place_prio_q;
	logic        before_q, found_q, changed_q;
	logic [1:0]  reason_q, status_q;
	logic [7:0]  lock_q;
	logic [8:0]  top_q;
	logic signed [TL_W-1:0] tl_s1;

	// single read port into the priority table
	logic [ID_W-1:0] prd_addr;
	logic [7:0]      prd;
	logic [LEN_W-1:0] idx_p1, idx_m1;
	logic            place_hit, full, cur_hit;
	logic            tk_add;
	logic signed [TL_W-1:0] tk_opa, tk_res;
	logic            tk_nonpos;

	assign idx_p1 = idx_q + 5'd1;
	assign idx_m1 = idx_q - 5'd1;
	assign full   = (len_q >= LEN_W'(NUM_THREADS));
	assign cur_hit = (tid_q == cur_q);

	always_comb begin
		case (state_q)
			S_PSTART: prd_addr = place_id_q;
			S_PSCAN:  prd_addr = queue_q[idx_q[ID_W-1:0]];
			S_TOP:    prd_addr = queue_q[0];
			default:  prd_addr = cur_q;
		endcase
		prd = prio_q[prd_addr];
		place_hit = before_q ? (place_prio_q <= prd) : (place_prio_q < prd);
	end

	// time-left unit
	assign tk_add = (state_q == S_TICK2);
	assign tk_opa = tk_add ? tl_s1 : tl_q[cur_q];

	prqs_tick u_tick (
		.add_step (tk_add),
		.opa      (tk_opa),
		.elapsed  (elap_q),
		.quantum  (quantum_q),
		.result   (tk_res),
		.nonpos   (tk_nonpos)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = S_DISP;
			S_DISP: begin
				unique case (op_q)
					OP_ENQ:    state_d = cur_hit ? S_TOP : S_FIND;
					OP_REM:    state_d = S_FIND;
					OP_SWITCH: begin
						if (reason_q == RS_NONE || lock_q != 8'd0)
							state_d = S_TOP;
						else
							state_d = run_q ? S_PSTART : S_SWPOP;
					end
					OP_TICK:   state_d = rr_q[cur_q] ? S_TICK1 : S_TOP;
					OP_SETP:   state_d = (!cur_hit && run_q) ? S_FIND : S_TOP;
					default:   state_d = S_TOP;
				endcase
			end
			S_FIND: begin
				if (idx_q == len_q || queue_q[idx_q[ID_W-1:0]] == tid_q)
					state_d = S_FDONE;
			end
			S_FDONE: begin
				if (op_q == OP_ENQ)
					state_d = (!found_q && full) ? S_TOP :
						(found_q ? S_REMOVE : S_PSTART);
				else
					state_d = found_q ? S_REMOVE : S_TOP;
			end
			S_REMOVE: if (idx_p1 >= len_q) state_d = ret_q;
			S_PSTART: begin
				if (full)
					state_d = (op_q == OP_SWITCH) ? S_SWPOP : S_MARK;
				else
					state_d = S_PSCAN;
			end
			S_PSCAN:  if (idx_q == len_q || place_hit) state_d = S_PSHIFT;
			S_PSHIFT: begin
				if (idx_q == pos_q)
					state_d = (op_q == OP_SWITCH) ? S_SWPOP : S_MARK;
			end
			S_MARK:   state_d = S_TOP;
			S_SWPOP:  state_d = (len_q == 5'd0) ? S_TOP : S_REMOVE;
			S_TICK1:  state_d = S_TICK2;
			S_TICK2:  state_d = S_TOP;
			S_TOP:    state_d = S_OUT;
			S_OUT:    if (out_ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ready  = (state_q == S_IDLE);
		out_valid = (state_q == S_OUT);
		cfg_ready = 1'b1;
	end

	assign active_id      = cur_q;
	assign changed        = changed_q;
	assign resched_reason = reason_q;
	assign switch_request = (reason_q != RS_NONE) && (lock_q == 8'd0);
	assign top_prio       = top_q;
	assign queue_count    = len_q;
	assign status         = status_q;

	// queue slots: no reset, only entries below len_q are read
	always_ff @(posedge clk) begin
		case (state_q)
			S_REMOVE: if (idx_p1 < len_q)
				queue_q[idx_q[ID_W-1:0]] <= queue_q[idx_p1[ID_W-1:0]];
			S_PSHIFT: begin
				if (idx_q == pos_q)
					queue_q[pos_q[ID_W-1:0]] <= place_id_q;
				else
					queue_q[idx_q[ID_W-1:0]] <= queue_q[idx_m1[ID_W-1:0]];
			end
			default: ;
		endcase
	end

	// sequencer and thread tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_q     <= S_TOP;
			quantum_q <= QUANTUM_RESET;
			len_q     <= '0;
			cur_q     <= '0;
			reason_q  <= RS_NONE;
			lock_q    <= '0;
			top_q     <= EMPTY_PRIO;
			status_q  <= ST_OK;
			changed_q <= 1'b0;
			for (int k = 0; k < NUM_THREADS; k++) begin
				prio_q[k] <= 8'd255;
				rr_q[k]   <= 1'b1;
				tl_q[k]   <= TL_RESET;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid)
				quantum_q <= cfg_data;
			case (state_q)
				S_IDLE: if (in_valid) begin
					op_q <= op; tid_q <= thread_id; pin_q <= prio;
					run_q <= runnable; pol_q <= policy_rr; elap_q <= elapsed_ns;
					status_q <= ST_OK; changed_q <= 1'b0; idx_q <= '0;
				end
				S_DISP: begin
					case (op_q)
						OP_ENQ: if (cur_hit) status_q <= ST_NOTFOUND;
						OP_SWITCH: begin
							place_id_q <= cur_q;
							before_q   <= (reason_q == RS_PREEMPT);
						end
						OP_YIELD: if (top_q <= {1'b0, prd}) reason_q <= RS_SWITCH;
						OP_SETP: begin
							if (cur_hit) begin
								prio_q[tid_q] <= pin_q;
								if ({1'b0, pin_q} > top_q && reason_q == RS_NONE)
									reason_q <= RS_PREEMPT;
							end else if (!run_q)
								prio_q[tid_q] <= pin_q;
						end
						OP_SETPOL: begin
							tl_q[tid_q] <= $signed({3'd0, quantum_q});
							rr_q[tid_q] <= pol_q;
						end
						OP_LOCK:   if (lock_q != 8'd255) lock_q <= lock_q + 8'd1;
						OP_UNLOCK: if (lock_q != 8'd0) lock_q <= lock_q - 8'd1;
						default: ;
					endcase
				end
				S_FIND: begin
					if (idx_q == len_q)
						found_q <= 1'b0;
					else if (queue_q[idx_q[ID_W-1:0]] == tid_q) begin
						found_q <= 1'b1;
						slot_q  <= idx_q;
					end else
						idx_q <= idx_p1;
				end
				S_FDONE: begin
					idx_q      <= slot_q;
					place_id_q <= tid_q;
					before_q   <= 1'b0;
					ret_q      <= (op_q == OP_REM) ? S_TOP : S_PSTART;
					if (op_q == OP_ENQ) begin
						if (!found_q && full)
							status_q <= ST_FULL;
						else
							prio_q[tid_q] <= pin_q;
					end else begin
						if (op_q == OP_SETP)
							prio_q[tid_q] <= pin_q;
						if (!found_q)
							status_q <= ST_NOTFOUND;
					end
				end
				S_REMOVE: begin
					if (idx_p1 < len_q)
						idx_q <= idx_p1;
					else
						len_q <= len_q - 5'd1;
				end
				S_PSTART: begin
					if (full)
						status_q <= ST_FULL;
					place_prio_q <= prd;
					idx_q        <= '0;
				end
				S_PSCAN: begin
					if (idx_q == len_q || place_hit) begin
						pos_q <= idx_q;
						idx_q <= len_q;
					end else
						idx_q <= idx_p1;
				end
				S_PSHIFT: begin
					if (idx_q == pos_q)
						len_q <= len_q + 5'd1;
					else
						idx_q <= idx_m1;
				end
				S_MARK: if (pin_q < prd && reason_q == RS_NONE) reason_q <= RS_PREEMPT;
				S_SWPOP: begin
					reason_q <= RS_NONE;
					if (len_q == 5'd0)
						status_q <= ST_NOTFOUND;
					else begin
						cur_q     <= queue_q[0];
						changed_q <= (queue_q[0] != cur_q);
						idx_q     <= '0;
						ret_q     <= S_TOP;
					end
				end
				S_TICK1: tl_s1 <= tk_res;
				S_TICK2: begin
					if (tk_nonpos) begin
						tl_q[cur_q] <= tk_res;
						if (top_q <= {1'b0, prd})
							reason_q <= RS_SWITCH;
					end else
						tl_q[cur_q] <= tl_s1;
				end
				S_TOP: top_q <= (len_q == 5'd0) ? EMPTY_PRIO : {1'b0, prd};
				default: ;
			endcase
		end
	end

	// checks
	a_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(NUM_THREADS)) else $error("queue length overflow");
	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && queue_count == 5'd0) |-> (top_prio == EMPTY_PRIO))
		else $error("empty queue without empty priority");
	a_changed_switch: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && changed) |-> (op_q == OP_SWITCH))
		else $error("changed flagged outside switch");
endmodule

### sv/prqs_tick.sv
// Shared saturating adder for the time-left arithmetic.
// Depends on prqs_pkg. Step 0 charges elapsed time, step 1 adds the quantum.
module prqs_tick (
	input  logic                           add_step,
	input  logic signed [prqs_pkg::TL_W-1:0] opa,
	input  logic [31:0]                    elapsed,
	input  logic [30:0]                    quantum,
	output logic signed [prqs_pkg::TL_W-1:0] result,
	output logic                           nonpos
);
	import prqs_pkg::*;

	logic signed [TL_W:0] b;
	logic signed [TL_W:0] sum;
	localparam logic signed [TL_W:0] SAT_MAX = (35'sd1 <<< (TL_W-1)) - 35'sd1;
	localparam logic signed [TL_W:0] SAT_MIN = -(35'sd1 <<< (TL_W-1));

	// one adder: subtract elapsed or add quantum, then clamp to 34 bits
	always_comb begin
		b = add_step ? $signed({4'd0, quantum}) : -$signed({3'd0, elapsed});
		sum = $signed({opa[TL_W-1], opa}) + b;
		if (sum > SAT_MAX)
			result = SAT_MAX[TL_W-1:0];
		else if (sum < SAT_MIN)
			result = SAT_MIN[TL_W-1:0];
		else
			result = sum[TL_W-1:0];
		nonpos = (opa <= 0);
	end
endmodule
